// File: rtl/ssp_pkg.sv
// ----------------------------------------------------------------------------
// Square spiral offset package
// Shared widths, defaults and the offset type.
// ----------------------------------------------------------------------------
package ssp_pkg;

   localparam int INDEX_BITS_DEFAULT = 16;
   localparam int ROOT_BITS_DEFAULT  = (INDEX_BITS_DEFAULT + 1) / 2;
   localparam int OFFSET_BITS        = 9;

   typedef logic signed [OFFSET_BITS-1:0] offset_type;

endpackage

// File: rtl/ssp_req_if.sv
// ----------------------------------------------------------------------------
// Square spiral request channel
// Valid/ready channel that carries one point index per item.
// ----------------------------------------------------------------------------
interface ssp_req_if #(
   parameter int INDEX_BITS = ssp_pkg::INDEX_BITS_DEFAULT
);
   import ssp_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [INDEX_BITS-1:0] point_index;

   modport source (output valid, output point_index, input ready);
   modport sink   (input valid, input point_index, output ready);

endinterface

// File: rtl/ssp_rsp_if.sv
// ----------------------------------------------------------------------------
// Square spiral response channel
// Valid/ready channel that carries one signed offset pair per item.
// ----------------------------------------------------------------------------
interface ssp_rsp_if;
   import ssp_pkg::*;

   logic       valid;
   logic       ready;
   offset_type offset_x;
   offset_type offset_y;

   modport source (output valid, output offset_x, output offset_y, input ready);
   modport sink   (input valid, input offset_x, input offset_y, output ready);

endinterface

// File: rtl/square_spiral_offset.sv
// ----------------------------------------------------------------------------
// Square spiral offset
// Maps a point index to its signed offset on a square spiral around a centre.
// ----------------------------------------------------------------------------
// Takes one index per cycle unless a stalled response has filled the pipeline, and
// returns its offset pair from the last pipeline stage. The integer square root
// resolves one root bit per pipeline stage; two more stages place the index on
// its ring and pick the side. A stalled response holds its stage while empty
// stages upstream keep filling.
// ----------------------------------------------------------------------------
module square_spiral_offset #(
   parameter int INDEX_BITS = ssp_pkg::INDEX_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   ssp_req_if.sink   req_ch,
   ssp_rsp_if.source rsp_ch
);
   import ssp_pkg::*;

   localparam int ROOT_BITS  = (INDEX_BITS + 1) / 2;
   localparam int N_BITS     = 2 * ROOT_BITS;
   localparam int REM_BITS   = ROOT_BITS + 2;
   localparam int K_BITS     = ROOT_BITS + 1;
   localparam int D_BITS     = ROOT_BITS + 3;
   localparam int W_BITS     = ROOT_BITS + 5;
   localparam int NUM_STAGES = ROOT_BITS + 2;
   localparam int RING_STAGE = ROOT_BITS;
   localparam int SIDE_STAGE = ROOT_BITS + 1;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] up_valid;
   logic [NUM_STAGES:0]   stage_ready;

   logic [N_BITS-1:0]    idx_ff  [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_ff [ROOT_BITS];
   logic [REM_BITS-1:0]  rem_ff  [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_in [ROOT_BITS];
   logic [REM_BITS-1:0]  rem_in  [ROOT_BITS];

   logic                 centre_ff, centre_in;
   logic [K_BITS-1:0]    ring_k_ff, ring_k_in;
   logic [ROOT_BITS-1:0] half_ff, half_in;
   logic [D_BITS-1:0]    pos_ff, pos_in;

   offset_type offset_x_ff, offset_x_in;
   offset_type offset_y_ff, offset_y_in;

   logic signed [W_BITS-1:0] k_w, r_w, d_w, lim_w, rest_w, x_w, y_w;

   logic in_accept;
   logic out_accept;

   // handshake: a stage loads when it is empty or its item moves on
   assign stage_ready[NUM_STAGES] = rsp_ch.ready;
   assign up_valid[0]             = req_ch.valid;

   genvar j;
   generate
      for (j = 0; j < NUM_STAGES; j++) begin : g_ctrl
         assign stage_ready[j] = !valid_ff[j] || stage_ready[j+1];
         if (j > 0) begin : g_up
            assign up_valid[j] = valid_ff[j-1];
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[j] <= 1'b0;
            end else if (stage_ready[j]) begin
               valid_ff[j] <= up_valid[j];
            end
         end
      end

      // square root, one digit per stage, most significant first
      for (j = 0; j < ROOT_BITS; j++) begin : g_root
         logic [N_BITS-1:0]    idx_src;
         logic [ROOT_BITS-1:0] root_src;
         logic [REM_BITS-1:0]  rem_src;

         if (j == 0) begin : g_first
            assign idx_src  = N_BITS'(req_ch.point_index);
            assign root_src = '0;
            assign rem_src  = '0;
         end else begin : g_next
            assign idx_src  = idx_ff[j-1];
            assign root_src = root_ff[j-1];
            assign rem_src  = rem_ff[j-1];
         end

         ssp_isqrt_step #(
            .ROOT_BITS (ROOT_BITS),
            .DIGIT     (ROOT_BITS - 1 - j)
         ) u_step (
            .idx       (idx_src),
            .root_prev (root_src),
            .rem_prev  (rem_src),
            .root_new  (root_in[j]),
            .rem_new   (rem_in[j])
         );

         always_ff @(posedge clock) begin
            if (stage_ready[j] && up_valid[j]) begin
               idx_ff[j]  <= idx_src;
               root_ff[j] <= root_in[j];
               rem_ff[j]  <= rem_in[j];
            end
         end
      end
   endgenerate

   // ring: side k, half side r and position d from the ring's first index
   always_comb begin
      centre_in = (root_ff[ROOT_BITS-1] == '0);
      if (root_ff[ROOT_BITS-1][0]) begin
         ring_k_in = K_BITS'(root_ff[ROOT_BITS-1]) + K_BITS'(2);
         pos_in    = D_BITS'(rem_ff[ROOT_BITS-1]);
      end else begin
         ring_k_in = K_BITS'(root_ff[ROOT_BITS-1]) + K_BITS'(1);
         pos_in    = D_BITS'(rem_ff[ROOT_BITS-1])
                   + (D_BITS'(root_ff[ROOT_BITS-1]) << 1) - D_BITS'(1);
      end
      half_in = ring_k_in[K_BITS-1:1];
   end

   always_ff @(posedge clock) begin
      if (stage_ready[RING_STAGE] && up_valid[RING_STAGE]) begin
         centre_ff <= centre_in;
         ring_k_ff <= ring_k_in;
         half_ff   <= half_in;
         pos_ff    <= pos_in;
      end
   end

   // side: centre, bottom row, top row, or alternating columns
   always_comb begin
      k_w    = W_BITS'(ring_k_ff);
      r_w    = W_BITS'(half_ff);
      d_w    = W_BITS'(pos_ff);
      lim_w  = k_w + (k_w <<< 1) - W_BITS'(4);
      rest_w = d_w - k_w;
      priority if (centre_ff) begin
         x_w = '0;
         y_w = '0;
      end else if (d_w < k_w) begin
         x_w = r_w - d_w;
         y_w = r_w;
      end else if (d_w >= lim_w) begin
         x_w = (k_w <<< 2) - W_BITS'(5) - d_w - r_w;
         y_w = -r_w;
      end else begin
         x_w = rest_w[0] ? -r_w : r_w;
         y_w = r_w - W_BITS'(1) - (rest_w >>> 1);
      end
      offset_x_in = OFFSET_BITS'(x_w);
      offset_y_in = OFFSET_BITS'(y_w);
   end

   always_ff @(posedge clock) begin
      if (stage_ready[SIDE_STAGE] && up_valid[SIDE_STAGE]) begin
         offset_x_ff <= offset_x_in;
         offset_y_ff <= offset_y_in;
      end
   end

   assign req_ch.ready    = stage_ready[0];
   assign rsp_ch.valid    = valid_ff[SIDE_STAGE];
   assign rsp_ch.offset_x = offset_x_ff;
   assign rsp_ch.offset_y = offset_y_ff;

   assign in_accept  = req_ch.valid && req_ch.ready;
   assign out_accept = rsp_ch.valid && rsp_ch.ready;

   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (&valid_ff) && !rsp_ch.ready)
      else $error("input blocked while the pipeline has room");

   a_item_count: assert property (@(posedge clock) disable iff (reset)
      !reset |=> $countones(valid_ff) == $past($countones(valid_ff))
                 + int'($past(in_accept)) - int'($past(out_accept)))
      else $error("item lost or repeated in the pipeline");

   a_centre_zero: assert property (@(posedge clock) disable iff (reset)
      valid_ff[RING_STAGE] && stage_ready[SIDE_STAGE] && centre_ff |=>
         valid_ff[SIDE_STAGE] && offset_x_ff == '0 && offset_y_ff == '0)
      else $error("centre index gave a nonzero offset");

endmodule

// File: rtl/ssp_isqrt_step.sv
// ----------------------------------------------------------------------------
// Square spiral root digit step
// One digit of the restoring integer square root: brings in two index bits,
// tries the next root bit and keeps the partial remainder.
// ----------------------------------------------------------------------------
module ssp_isqrt_step #(
   parameter int ROOT_BITS = ssp_pkg::ROOT_BITS_DEFAULT,
   parameter int DIGIT     = 0
) (
   input  logic [2*ROOT_BITS-1:0] idx,
   input  logic [ROOT_BITS-1:0]   root_prev,
   input  logic [ROOT_BITS+1:0]   rem_prev,
   output logic [ROOT_BITS-1:0]   root_new,
   output logic [ROOT_BITS+1:0]   rem_new
);
   import ssp_pkg::*;

   localparam int REM_BITS = ROOT_BITS + 2;
   localparam int TRY_BITS = REM_BITS + 2;

   logic [TRY_BITS-1:0] shifted;
   logic [TRY_BITS-1:0] trial;
   logic [TRY_BITS-1:0] diff;
   logic                take;

   always_comb begin
      shifted  = {rem_prev, idx[2*DIGIT +: 2]};
      trial    = TRY_BITS'({root_prev, 2'b01});
      diff     = shifted - trial;
      take     = (shifted >= trial);
      root_new = {root_prev[ROOT_BITS-2:0], take};
      rem_new  = take ? diff[REM_BITS-1:0] : shifted[REM_BITS-1:0];
   end

endmodule
